// File: hw/rtl/spsq_pkg.sv
// Types, codes and constants shared by the sorted priority queue modules.
package spsq_pkg;

    localparam int unsigned DEPTH_DEF = 16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic               command;
        logic signed [15:0] priority_req;
        logic        [15:0] event_tag;
    } t_in_item;

    typedef struct packed {
        logic [15:0] popped_tag;
        logic        popped_valid;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] pri;
        logic        [15:0] tag;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_cell_ctrl;

    typedef struct packed {
        logic occ;
        logic tail;
    } t_cell_pos;

endpackage

// File: hw/rtl/stable_sorted_priority_queue.sv
// Stable sorted priority queue of event tags built from a chain of compare-and-shift cells.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): command 0 pushes event_tag with
// the signed priority_req, command 1 pops the front entry. Lower priorities leave first,
// equal priorities leave in arrival order.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one result per item,
// giving the popped tag, a valid flag, a status (ok, pop on empty, push dropped on full)
// and the occupancy after the item.
// The result is written into an output register at the input transfer and appears from the next cycle.
// Throughput: one item per cycle while results are taken; every cell compares against the
// pushed priority and shifts in the same cycle, so the chain length does not slow the rate.
// When the receiver stalls, the result is held and the input accepts one more item only
// as the held result is taken in the same cycle.
// Reset (synchronous, active low) empties the queue and drops any pending result; cell
// contents are not cleared, only the count, which marks which cells hold entries.
module stable_sorted_priority_queue
    import spsq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_out_item     n_out_item;

    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    t_cell_ctrl    w_ctrl;

    t_entry        w_entry [DEPTH];
    logic          w_gt    [DEPTH];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_ctrl.push      = w_accept && (i_in_item.command == CMD_PUSH) && !w_full;
    assign w_ctrl.pop       = w_accept && (i_in_item.command == CMD_POP) && !w_empty;
    assign w_ctrl.entry.pri = i_in_item.priority_req;
    assign w_ctrl.entry.tag = i_in_item.event_tag;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_pos w_pos;
        t_entry    w_left;
        t_entry    w_right;
        logic      w_left_gt;

        assign w_pos.occ  = (CW'(g) < r_count);
        assign w_pos.tail = (CW'(g) == r_count);

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        spsq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_pos     (w_pos),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end

        n_out_item              = '0;
        n_out_item.occupancy    = 5'(n_count);
        unique case (i_in_item.command)
            CMD_PUSH: begin
                if (w_full) begin
                    n_out_item.status = ST_PUSH_FULL;
                end
            end
            CMD_POP: begin
                if (w_empty) begin
                    n_out_item.status = ST_POP_EMPTY;
                end else begin
                    n_out_item.popped_tag   = w_entry[0].tag;
                    n_out_item.popped_valid = 1'b1;
                end
            end
            default: begin
                n_out_item.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// File: hw/rtl/spsq_cell.sv
// One storage cell of the sorted chain: compare against the pushed entry and shift.
module spsq_cell
    import spsq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_cell_pos  i_pos,
    input  t_entry     i_left,
    input  logic       i_left_gt,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_gt    = i_pos.occ && (r_entry.pri > i_ctrl.entry.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            priority if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_pos.tail) begin
                n_entry = i_ctrl.entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hw/rtl/spsq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spsq_checker
    import spsq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.command == CMD_PUSH |=>
            o_out_valid && !o_out_item.popped_valid)
        else $error("push returned a popped entry");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_POP_EMPTY |-> o_out_item.occupancy == '0)
        else $error("empty pop with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_PUSH_FULL |->
            o_out_item.occupancy == 5'(DEPTH))
        else $error("full push with wrong occupancy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind stable_sorted_priority_queue spsq_checker #(.DEPTH(DEPTH)) u_spsq_checker (.*);

// File: test/stable_sorted_priority_queue_tb.sv
// Self-checking testbench for the stable sorted priority queue: directed table, then random traffic.
module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spsq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int BLOCK        = 30;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int SCRIPT_ROWS  = 32;
    localparam int PEND_SLOTS   = 16;

    typedef struct packed {
        t_in_item  it;
        logic      typed;
        t_out_item want;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    logic      row_typed   = 1'b0;
    t_out_item row_want    = '0;
    logic      rx_quiet    = 1'b0;
    int        rx_wait     = 0;

    t_entry    held [DEPTH];
    int        held_count  = 0;
    t_out_item pend_buf [PEND_SLOTS];
    int        pend_head   = 0;
    int        pend_tail   = 0;
    t_row      script [SCRIPT_ROWS];
    int        script_len  = 0;

    int errors      = 0;
    int idle_cycles = 0;
    int n_checked   = 0;
    int n_push      = 0;
    int n_full      = 0;
    int n_pop       = 0;
    int n_empty     = 0;
    int peak_occ    = 0;

    stable_sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item apply_queue_command(t_in_item it);
        t_out_item r;
        int        pos;
        r = '0;
        if (it.command == CMD_PUSH) begin
            if (held_count >= DEPTH) begin
                r.status = ST_PUSH_FULL;
            end else begin
                pos = held_count;
                while (pos > 0 && $signed(held[pos-1].pri) > $signed(it.priority_req)) begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos].pri = it.priority_req;
                held[pos].tag = it.event_tag;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_POP_EMPTY;
        end else begin
            r.popped_tag   = held[0].tag;
            r.popped_valid = 1'b1;
            for (int i = 1; i < held_count; i++) held[i-1] = held[i];
            held_count--;
        end
        r.occupancy = 5'(held_count);
        return r;
    endfunction

    function automatic void add_row(logic cmd, logic signed [15:0] pri, logic [15:0] tag,
                                    logic typed, t_out_item want);
        t_row r;
        r.it.command      = cmd;
        r.it.priority_req = pri;
        r.it.event_tag    = tag;
        r.typed           = typed;
        r.want            = want;
        script[script_len] = r;
        script_len++;
    endfunction

    task automatic send_item(t_in_item it, logic typed, t_out_item want, logic with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int s;
        if (o_out_valid && i_out_ready) begin
            s = rx_quiet ? 0 : $urandom_range(0, 17);
            rx_wait     <= s;
            i_out_ready <= (s == 0);
        end else if (!i_out_ready) begin
            if (rx_wait <= 1) i_out_ready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
    end

    always @(posedge i_clk) begin : check_port
        t_out_item want;
        t_out_item got;
        logic      in_xfer;
        logic      out_xfer;
        if (i_rst_n) begin
            in_xfer  = i_in_valid && o_in_ready;
            out_xfer = o_out_valid && i_out_ready;
            if (in_xfer) begin
                want = apply_queue_command(i_in_item);
                if (row_typed) want = row_want;
                pend_buf[pend_tail % PEND_SLOTS] = want;
                pend_tail++;
                if (i_in_item.command == CMD_PUSH) begin
                    n_push++;
                    if (want.status == ST_PUSH_FULL) n_full++;
                end else begin
                    n_pop++;
                    if (want.status == ST_POP_EMPTY) n_empty++;
                end
                if (int'(want.occupancy) > peak_occ) peak_occ = int'(want.occupancy);
            end
            if (out_xfer) begin
                got = o_out_item;
                if (pend_tail == pend_head) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: %p", $realtime, got);
                end else begin
                    want = pend_buf[pend_head % PEND_SLOTS];
                    pend_head++;
                    n_checked++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch (expected/actual) tag %h/%h valid %b/%b",
                                      " status %0d/%0d occupancy %0d/%0d"}, $realtime,
                                     want.popped_tag, got.popped_tag, want.popped_valid,
                                     got.popped_valid, want.status, got.status,
                                     want.occupancy, got.occupancy);
                    end
                end
            end
            if (in_xfer || out_xfer) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                    $display("stable_sorted_priority_queue_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        int                 fill_pri [11];
        t_in_item           it;
        int                 push_pct;
        int                 pri_mode;
        logic               gaps_on;
        logic signed [15:0] pri;

        fill_pri = '{-32768, 32767, 0, -1, 1, -2, 2, 16384, -16384, 0, 32767};

        add_row(CMD_POP, 16'sd0, 16'h0000, 1'b1, '{16'h0000, 1'b0, ST_POP_EMPTY, 5'd0});
        add_row(CMD_PUSH, 16'sh8000, 16'hffff, 1'b1, '{16'h0000, 1'b0, ST_OK, 5'd1});
        add_row(CMD_PUSH, 16'sh7fff, 16'h0000, 1'b1, '{16'h0000, 1'b0, ST_OK, 5'd2});
        add_row(CMD_PUSH, 16'sd0, 16'h1234, 1'b1, '{16'h0000, 1'b0, ST_OK, 5'd3});
        add_row(CMD_PUSH, 16'sd0, 16'h5678, 1'b1, '{16'h0000, 1'b0, ST_OK, 5'd4});
        add_row(CMD_PUSH, 16'sh7fff, 16'haaaa, 1'b1, '{16'h0000, 1'b0, ST_OK, 5'd5});
        add_row(CMD_PUSH, 16'sh8000, 16'h5555, 1'b1, '{16'h0000, 1'b0, ST_OK, 5'd6});
        add_row(CMD_POP, 16'sh7fff, 16'hffff, 1'b1, '{16'hffff, 1'b1, ST_OK, 5'd5});
        foreach (fill_pri[k])
            add_row(CMD_PUSH, 16'(fill_pri[k]), 16'h0100 + 16'(k), 1'b0, '0);
        add_row(CMD_PUSH, 16'sd123, 16'hbeef, 1'b1, '{16'h0000, 1'b0, ST_PUSH_FULL, 5'd16});
        repeat (5) add_row(CMD_POP, 16'sd0, 16'h0000, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < script_len; r++)
            send_item(script[r].it, script[r].typed, script[r].want, 1'b1);

        for (int b = 0; b < RANDOM_ITEMS / BLOCK; b++) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = 100;
            endcase
            pri_mode = $urandom_range(0, 2);
            gaps_on  = ($urandom_range(0, 2) != 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            if (b == RANDOM_ITEMS / BLOCK / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pend_tail != pend_head) @(posedge i_clk);
            end
            for (int k = 0; k < BLOCK; k++) begin
                case (pri_mode)
                    0: pri = 16'($urandom_range(0, 6)) - 16'sd3;
                    1: pri = 16'($urandom);
                    default:
                        case ($urandom_range(0, 3))
                            0:       pri = 16'sh8000;
                            1:       pri = 16'sh7fff;
                            2:       pri = 16'sh0000;
                            default: pri = 16'shffff;
                        endcase
                endcase
                it.command      = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
                it.priority_req = pri;
                it.event_tag    = 16'($urandom);
                send_item(it, 1'b0, '0, gaps_on);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_tail != pend_head) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d pushes (%0d dropped on full) and %0d pops (%0d on empty),",
                 n_push, n_full, n_pop, n_empty);
        $display("peak %0d held, %0d results compared, %0d mismatches",
                 peak_occ, n_checked, errors);
        if (errors == 0) begin
            $display("stable_sorted_priority_queue_tb: done, clean");
        end else begin
            $display("stable_sorted_priority_queue_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: stable_sorted_priority_queue.f
hw/rtl/spsq_pkg.sv
hw/rtl/spsq_cell.sv
hw/rtl/stable_sorted_priority_queue.sv
hw/rtl/spsq_checker.sv
test/stable_sorted_priority_queue_tb.sv
